FILE: rtl/sctc_pkg.sv
// Shared types and constants for the scan-code to character FIFO.
// No dependencies; imported by every other module of the block.
`default_nettype none

package sctc_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_SCAN = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Scan codes with a special meaning (scan code set 1).
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_EXTEND       = 8'he0;

    // Keymap geometry: 512 rows of two columns.
    localparam int KEY_ROWS   = 512;
    localparam int KEY_ADDR_W = $clog2(KEY_ROWS * 2);

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 4;

    // Command kinds handed from the front to the back.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PUSH = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sctc_front.sv
// Front end: accepts input words, tracks shift and extended state and
// reads or loads the keymap. Depends on sctc_pkg.
`default_nettype none

module sctc_front
    import sctc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] scan_byte,
    input  wire logic [8:0] map_index,
    input  wire logic       map_shifted,
    input  wire logic [7:0] map_char,
    output logic            cmd_valid,
    input  wire logic       cmd_stall,
    output cmd_t            cmd
);

    logic [7:0] key_mem [KEY_ROWS * 2];
    logic [7:0] key_q_reg;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       shift_reg;
    logic       shift_next;
    logic       ext_reg;
    logic       ext_next;

    logic                  accept;
    logic                  advance;
    logic [KEY_ADDR_W-1:0] look_addr;
    logic [KEY_ADDR_W-1:0] load_addr;

    assign advance  = stage_valid_reg && !cmd_stall;
    assign in_stall = stage_valid_reg && cmd_stall;
    assign accept   = in_valid && !in_stall;

    // Row is the scan byte plus 256 when extended; column is the shift flag.
    assign look_addr = {ext_reg, scan_byte, shift_reg};
    assign load_addr = {map_index, map_shifted};

    always_comb
    begin
        kind_next  = KIND_NONE;
        shift_next = shift_reg;
        ext_next   = ext_reg;
        case (operation)
            OP_SCAN:
            begin
                ext_next = 1'b0;
                if (ext_reg)
                begin
                    // An extended code never matches the special bytes.
                    if (!scan_byte[7])
                        kind_next = KIND_PUSH;
                end
                else if (scan_byte inside {SC_LSHIFT_MAKE, SC_RSHIFT_MAKE})
                    shift_next = 1'b1;
                else if (scan_byte inside {SC_LSHIFT_BREAK, SC_RSHIFT_BREAK})
                    shift_next = 1'b0;
                else if (scan_byte == SC_EXTEND)
                    ext_next = 1'b1;
                else if (!scan_byte[7])
                    kind_next = KIND_PUSH;
            end
            OP_READ: kind_next = KIND_POP;
            OP_LOAD: kind_next = KIND_NONE;
            default: kind_next = KIND_NONE;
        endcase
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            kind_reg        <= KIND_NONE;
            shift_reg       <= 1'b0;
            ext_reg         <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                kind_reg  <= kind_next;
                shift_reg <= shift_next;
                ext_reg   <= ext_next;
            end
        end
    end

    // The keymap is read as the word is taken, so the data register holds
    // with the stage while the queue is full.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (operation == OP_LOAD)
                key_mem[load_addr] <= map_char;
            key_q_reg <= key_mem[look_addr];
        end
    end

    assign cmd_valid = stage_valid_reg;
    assign cmd.kind  = kind_reg;
    assign cmd.ch    = key_q_reg;

endmodule

`default_nettype wire

FILE: rtl/sctc_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on sctc_pkg for the command type and the queue depth.
`default_nettype none

module sctc_queue
    import sctc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_stall,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_stall,
    output cmd_t      pop_cmd
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign push_stall = (count_reg == CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/sctc_back.sv
// Back end: carries out push and pop commands on the character ring and
// drives the registered result word. Depends on sctc_pkg.
`default_nettype none

module sctc_back
    import sctc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire cmd_t       cmd,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            read_valid,
    output logic [7:0]      read_char,
    output logic [8:0]      fill_level,
    output logic            flushed
);

    localparam int SLOT_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    logic [7:0]        char_mem [FIFO_DEPTH];
    logic [7:0]        rd_q_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    logic [SLOT_W-1:0] wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [SLOT_W-1:0] rd_slot_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              read_valid_reg;
    logic              flushed_reg;
    logic [8:0]        fill_reg;

    logic              exec;
    logic              full;
    logic              is_push;
    logic              pop_ok;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign exec      = cmd_valid && (!out_valid_reg || !out_stall);
    assign cmd_stall = out_valid_reg && out_stall;
    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign is_push   = (cmd.kind == KIND_PUSH);
    assign pop_ok    = (cmd.kind == KIND_POP) && (count_reg != '0);
    assign mem_we    = exec && is_push;
    // A push into a full ring empties it first, so it lands in slot zero.
    assign mem_wa    = full ? '0 : wr_slot_reg;

    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        count_next   = count_reg;
        if (is_push)
        begin
            wr_slot_next = next_slot(mem_wa);
            if (full)
            begin
                rd_slot_next = '0;
                count_next   = CNT_W'(1);
            end
            else
                count_next = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            rd_slot_next = next_slot(rd_slot_reg);
            count_next   = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                wr_slot_reg   <= wr_slot_next;
                rd_slot_reg   <= rd_slot_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            char_mem[mem_wa] <= cmd.ch;
        if (exec && pop_ok)
            rd_q_reg <= char_mem[rd_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            read_valid_reg <= pop_ok;
            flushed_reg    <= is_push && full;
            fill_reg       <= 9'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_valid = read_valid_reg;
    assign read_char  = read_valid_reg ? rd_q_reg : 8'd0;
    assign fill_level = fill_reg;
    assign flushed    = flushed_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("ring count beyond its depth");

    a_flush_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && flushed_reg |-> !read_valid_reg)
        else $error("result word both flushed and read");

    a_flush_restart: assert property (@(posedge clk) disable iff (!rst_n)
        exec && is_push && full |=> count_reg == CNT_W'(1) && rd_slot_reg == '0)
        else $error("push into full ring did not restart it");

    a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        exec && cmd.kind == KIND_POP && count_reg == '0 |=>
            $stable(count_reg) && $stable(rd_slot_reg) && !read_valid_reg)
        else $error("read of empty ring changed state");
`endif

endmodule

`default_nettype wire

FILE: rtl/scan_code_to_char_fifo.sv
// Top level of the scan-code to character FIFO.
// Instantiates sctc_front, sctc_queue and sctc_back; depends on sctc_pkg.
`default_nettype none

// The block turns keyboard scan-code bytes into characters and queues them.
// Each input word carries an operation: a scan byte, a read of one character
// or the load of one keymap entry. Every accepted input word gives exactly
// one result word, in order, with read_valid, read_char, fill_level and
// flushed.
// Both channels use valid and stall; a word moves on a rising edge at which
// valid is high and stall is low.
// The front end takes one word per cycle while in_stall is low, updates
// the shift and extended flags and reads the keymap as the word is taken.
// A four-entry command queue sits between it and the back end, which works
// on the character ring and fills the result register.
// A word passes the front stage, the command queue and the result register.
// Throughput: one word per cycle while out_stall is low, set by the single
// keymap read and the single ring access each word needs.
// When the receiver stalls, the result register holds, the queue fills and
// in_stall rises once the front stage cannot move on.
// After reset the ring is empty and both flags are clear; the keymap has no
// defined contents and must be loaded before scan bytes that look it up.

module scan_code_to_char_fifo
    import sctc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] scan_byte,
    input  wire logic [8:0] map_index,
    input  wire logic       map_shifted,
    input  wire logic [7:0] map_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            read_valid,
    output logic [7:0]      read_char,
    output logic [8:0]      fill_level,
    output logic            flushed
);

    // Front stage to queue.
    logic front_valid;
    logic front_stall;
    cmd_t front_cmd;

    // Queue to back end.
    logic back_valid;
    logic back_stall;
    cmd_t back_cmd;

    sctc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .scan_byte   (scan_byte),
        .map_index   (map_index),
        .map_shifted (map_shifted),
        .map_char    (map_char),
        .cmd_valid   (front_valid),
        .cmd_stall   (front_stall),
        .cmd         (front_cmd)
    );

    sctc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_stall  (back_stall),
        .pop_cmd    (back_cmd)
    );

    sctc_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_stall  (back_stall),
        .cmd        (back_cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_valid (read_valid),
        .read_char  (read_char),
        .fill_level (fill_level),
        .flushed    (flushed)
    );

endmodule

`default_nettype wire

FILE: sim/sctc_checker.sv
// Checker for the scan-code to character FIFO: watches both channels,
// predicts each result word and compares it field by field.
// Depends on sctc_pkg for the operation and scan-code constants.

module sctc_checker
    import sctc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] scan_byte,
    input  wire logic [8:0] map_index,
    input  wire logic       map_shifted,
    input  wire logic [7:0] map_char,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       read_valid,
    input  wire logic [7:0] read_char,
    input  wire logic [8:0] fill_level,
    input  wire logic       flushed,
    output int              mismatches,
    output int              outstanding
);

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_char;
        logic [8:0] fill_level;
        logic       flushed;
    } char_result_t;

    char_result_t awaited_results[$];

    // Shadow copy of the block's state.
    logic [7:0] ring [FIFO_DEPTH];
    logic [7:0] keymap [KEY_ROWS * 2];
    int         wr_pos = 0;
    int         rd_pos = 0;
    int         held = 0;
    logic       shift_on = 1'b0;
    logic       extend_on = 1'b0;
    int         fail_count = 0;

    assign mismatches = fail_count;

    function automatic int step_pos(input int pos);
        return (pos + 1 >= FIFO_DEPTH) ? 0 : pos + 1;
    endfunction

    // Queue one character; a full ring is emptied first and the flag says so.
    function automatic logic push_char(input logic [7:0] ch);
        logic emptied;
        emptied = 1'b0;
        if (held >= FIFO_DEPTH) begin
            wr_pos = 0;
            rd_pos = 0;
            held = 0;
            emptied = 1'b1;
        end
        held++;
        ring[wr_pos] = ch;
        wr_pos = step_pos(wr_pos);
        return emptied;
    endfunction

    function automatic char_result_t predict_char_result(
        input logic [1:0] op,
        input logic [7:0] sb,
        input logic [8:0] idx,
        input logic       sh,
        input logic [7:0] chr
    );
        char_result_t res;
        logic [8:0]   code;
        res = '0;
        case (op)
            OP_SCAN:
            begin
                code = {extend_on, sb};
                extend_on = 1'b0;
                if (code == {1'b0, SC_LSHIFT_MAKE} || code == {1'b0, SC_RSHIFT_MAKE})
                    shift_on = 1'b1;
                else if (code == {1'b0, SC_LSHIFT_BREAK} || code == {1'b0, SC_RSHIFT_BREAK})
                    shift_on = 1'b0;
                else if (code == {1'b0, SC_EXTEND})
                    extend_on = 1'b1;
                else if (!code[7])
                    res.flushed = push_char(keymap[{code, shift_on}]);
            end
            OP_READ:
            begin
                if (held > 0) begin
                    held--;
                    res.read_valid = 1'b1;
                    res.read_char = ring[rd_pos];
                    rd_pos = step_pos(rd_pos);
                end
            end
            OP_LOAD:
            begin
                keymap[{idx, sh}] = chr;
            end
            default:
            begin
            end
        endcase
        res.fill_level = held[8:0];
        return res;
    endfunction

    // Sampled on the falling edge: everything is settled until the rising
    // edge that completes the handshake.
    always @(negedge clk)
    begin : watch
        char_result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    fail_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    if (read_valid !== want.read_valid) begin
                        $error("read_valid: expected %0d, actual %0d",
                               want.read_valid, read_valid);
                        fail_count++;
                    end
                    if (read_char !== want.read_char) begin
                        $error("read_char: expected %0h, actual %0h",
                               want.read_char, read_char);
                        fail_count++;
                    end
                    if (fill_level !== want.fill_level) begin
                        $error("fill_level: expected %0d, actual %0d",
                               want.fill_level, fill_level);
                        fail_count++;
                    end
                    if (flushed !== want.flushed) begin
                        $error("flushed: expected %0d, actual %0d",
                               want.flushed, flushed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(predict_char_result(operation, scan_byte,
                                          map_index, map_shifted, map_char));
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: sim/tb_top.sv
// Top of the testbench for the scan-code to character FIFO: clock, reset,
// keyboard-like stimulus, receiver stalls and the verdict.
// Depends on sctc_pkg, scan_code_to_char_fifo and sctc_checker.

module tb_top;
    import sctc_pkg::*;

    localparam int         FIFO_DEPTH  = 256;
    localparam int         TOTAL_ITEMS = 1250;
    localparam int         QUIET_ITEMS = 150;
    localparam int         HOLD_CYCLES = 80;
    localparam int         SETTLE      = 8;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic [7:0] scan_byte;
    logic [8:0] map_index;
    logic       map_shifted;
    logic [7:0] map_char;
    logic       out_valid;
    logic       out_stall;
    logic       read_valid;
    logic [7:0] read_char;
    logic [8:0] fill_level;
    logic       flushed;
    int         mismatches;
    int         outstanding;

    // Shared between the sender and the receiver. The sender raises
    // hold_req to ask for one long receiver hold-off, and sets quiet for the
    // closing stretch, in which neither side idles.
    bit         hold_req = 1'b0;
    bit         quiet = 1'b0;

    // The sender's own view of the decoder flags and of which keymap
    // entries have been loaded. A keymap entry is always loaded before any
    // scan byte can look it up, since unloaded entries have no defined value.
    bit         typed_shift = 1'b0;
    bit         typed_extend = 1'b0;
    bit         key_loaded [KEY_ROWS * 2];
    int         item_count = 0;

    scan_code_to_char_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .scan_byte  (scan_byte),
        .map_index  (map_index),
        .map_shifted(map_shifted),
        .map_char   (map_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_valid (read_valid),
        .read_char  (read_char),
        .fill_level (fill_level),
        .flushed    (flushed)
    );

    sctc_checker #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .scan_byte  (scan_byte),
        .map_index  (map_index),
        .map_shifted(map_shifted),
        .map_char   (map_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_valid (read_valid),
        .read_char  (read_char),
        .fill_level (fill_level),
        .flushed    (flushed),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offer one word and hold it until it has been taken. The task is
    // entered and left on a rising edge. Before the word there may be an
    // idle burst; the stall is looked at on the falling edge, where it is
    // stable until the edge that would take the word.
    task automatic send_word(
        input logic [1:0] op,
        input logic [7:0] sb,
        input logic [8:0] idx,
        input logic       sh,
        input logic [7:0] chr
    );
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        scan_byte   <= sb;
        map_index   <= idx;
        map_shifted <= sh;
        map_char    <= chr;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        if (op != OP_UNUSED)
            item_count++;
    endtask

    task automatic load_key(input logic [8:0] idx, input logic sh, input logic [7:0] chr);
        key_loaded[{idx, sh}] = 1'b1;
        send_word(OP_LOAD, 8'($urandom), idx, sh, chr);
    endtask

    task automatic read_word();
        send_word(OP_READ, 8'($urandom), 9'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Send one scan byte. The sender follows the shift and extended flags
    // as the block will, so it knows which keymap entry the byte will look
    // up, and loads that entry first if it has never been written.
    task automatic press_scan(input logic [7:0] sb);
        logic [8:0] code;
        logic       col;
        bit         lookup;
        code = {typed_extend, sb};
        col = typed_shift;
        lookup = 1'b0;
        if (typed_extend) begin
            // The extended mark lasts for one code only.
            typed_extend = 1'b0;
            lookup = !sb[7];
        end
        else if (sb == SC_LSHIFT_MAKE || sb == SC_RSHIFT_MAKE)
            typed_shift = 1'b1;
        else if (sb == SC_LSHIFT_BREAK || sb == SC_RSHIFT_BREAK)
            typed_shift = 1'b0;
        else if (sb == SC_EXTEND)
            typed_extend = 1'b1;
        else
            lookup = !sb[7];
        if (lookup && !key_loaded[{code, col}])
            load_key(code, col, 8'($urandom));
        send_word(OP_SCAN, sb, 9'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // One key stroke as a keyboard sends it: make and break code, now and
    // then wrapped in a shift press and release or given the extended prefix.
    task automatic type_key();
        logic [6:0] make;
        bit         use_shift;
        bit         use_ext;
        bit         right_side;
        make = 7'($urandom);
        use_shift = ($urandom_range(0, 3) == 0);
        use_ext = ($urandom_range(0, 4) == 0);
        right_side = 1'($urandom);
        if (use_shift)
            press_scan(right_side ? SC_RSHIFT_MAKE : SC_LSHIFT_MAKE);
        if (use_ext)
            press_scan(SC_EXTEND);
        press_scan({1'b0, make});
        if (use_ext)
            press_scan(SC_EXTEND);
        press_scan({1'b1, make});
        if (use_shift)
            press_scan(right_side ? SC_RSHIFT_BREAK : SC_LSHIFT_BREAK);
    endtask

    // A word of any kind, with random content.
    task automatic mixed_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            press_scan(8'($urandom));
        else if (pick <= 6)
            read_word();
        else if (pick <= 8)
            load_key(9'($urandom), 1'($urandom), 8'($urandom));
        else
            send_word(OP_UNUSED, 8'($urandom), 9'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Broken or meaningless input: unused operations, stray extended
    // prefixes and lone break codes.
    task automatic noise_word();
        case ($urandom_range(0, 2))
            0: send_word(OP_UNUSED, 8'($urandom), 9'($urandom), 1'($urandom),
                         8'($urandom));
            1: press_scan(SC_EXTEND);
            default: press_scan(8'($urandom) | 8'h80);
        endcase
    endtask

    // Receiver: random stall bursts between runs without stalls, one long
    // hold-off when the sender asks for it, and no stalls once quiet is set.
    initial
    begin : receiver
        int stall_left;
        int run_left;
        out_stall = 1'b0;
        stall_left = 0;
        run_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                // Long enough for the command queue to fill and the block
                // to stall its input while words keep being offered.
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                stall_left = 0;
                run_left = $urandom_range(1, 24);
            end
            else if (quiet) begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (run_left > 0) begin
                out_stall <= 1'b0;
                run_left--;
            end
            else begin
                out_stall <= 1'b0;
                run_left = $urandom_range(0, 24);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 17);
            end
        end
    end

    initial
    begin : sender
        bit hold_done;
        bit pause_done;
        bit flood_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        flood_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_SCAN;
        scan_byte = 8'h00;
        map_index = 9'h000;
        map_shifted = 1'b0;
        map_char = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. A read of the empty ring, then an unused
        // operation with every bit set, then the extremes of the keymap.
        read_word();
        send_word(OP_UNUSED, 8'hff, 9'h1ff, 1'b1, 8'hff);
        load_key(9'h000, 1'b0, 8'h00);
        load_key(9'h000, 1'b1, 8'hff);
        load_key(9'h1ff, 1'b1, 8'hff);
        // Plain and shifted look-ups with both shift keys.
        press_scan(8'h00);
        press_scan(SC_LSHIFT_MAKE);
        press_scan(8'h00);
        press_scan(SC_LSHIFT_BREAK);
        press_scan(SC_RSHIFT_MAKE);
        press_scan(8'h7f);
        press_scan(SC_RSHIFT_BREAK);
        // A break code is dropped.
        press_scan(8'hff);
        // Extended make is looked up in the upper half of the keymap, and
        // an extended break is dropped.
        press_scan(SC_EXTEND);
        press_scan(8'h1c);
        press_scan(SC_EXTEND);
        press_scan(8'h9c);
        // A doubled prefix: the second one is an extended break code and
        // clears the mark, so the code after it is an ordinary one.
        press_scan(SC_EXTEND);
        press_scan(SC_EXTEND);
        press_scan(8'h1c);
        // An extended shift code is an ordinary key, not a shift.
        press_scan(SC_EXTEND);
        press_scan(SC_LSHIFT_MAKE);
        // Pop everything back out and read past the end.
        repeat (7) read_word();

        // Random part, in bursts of one kind each.
        while (item_count < TOTAL_ITEMS) begin
            if (!hold_done && item_count >= 150) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (!flood_done && item_count >= 400) begin
                // Type well past the ring's depth without reading, so that
                // an insert finds it full, then drain it and read past empty.
                flood_done = 1'b1;
                repeat (FIFO_DEPTH + 50) press_scan({1'b0, 7'($urandom)});
                repeat (FIFO_DEPTH + 10) read_word();
            end
            if (!pause_done && item_count >= 800) begin
                // Let the block run dry before going on.
                pause_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            quiet = (item_count >= TOTAL_ITEMS - QUIET_ITEMS);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: repeat ($urandom_range(2, 8)) type_key();
                4, 5: repeat ($urandom_range(3, 30)) read_word();
                6, 7, 8: repeat ($urandom_range(10, 30)) mixed_word();
                default: repeat ($urandom_range(5, 15)) noise_word();
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin : watchdog
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: scan_code_to_char_fifo.f
rtl/sctc_pkg.sv
rtl/sctc_front.sv
rtl/sctc_queue.sv
rtl/sctc_back.sv
rtl/scan_code_to_char_fifo.sv
sim/sctc_checker.sv
sim/tb_top.sv
